>>> design/gprd_pkg.sv
// Shared constants and the result beat layout for the gamepad response decoder.
// No dependencies; imported by gprd_frame_buf and gamepad_response_decoder_unit.
`timescale 1ns / 1ps

package gprd_pkg;

  localparam int FRAME_DEPTH_DEF = 32;
  localparam int BYTE_W          = 8;

  // Mode bytes reported by the controller at frame position 2.
  localparam logic [7:0] MODE_DIGITAL  = 8'h41;
  localparam logic [7:0] MODE_ANALOG   = 8'h73;
  localparam logic [7:0] MODE_PRESSURE = 8'h79;
  // Command byte that asks the controller for its status.
  localparam logic [7:0] CMD_STATUS    = 8'h45;

  // Fixed frame positions (counted from 1) that the decoder looks at.
  localparam logic [4:0] POS_MODE      = 5'd2;
  localparam logic [4:0] POS_BTN_LO    = 5'd4;
  localparam logic [4:0] POS_BTN_HI    = 5'd5;
  localparam logic [4:0] POS_STICK0    = 5'd6;
  localparam logic [4:0] POS_STICK3    = 5'd9;
  localparam logic [4:0] POS_PRESS0    = 5'd10;
  localparam logic [4:0] POS_SWEEP_END = 5'd21;

  localparam logic [3:0] NUM_PRESS     = 4'd12;

  // Result beat, last declared field (entry) in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  pressure;
    logic [7:0]  left_y;
    logic [7:0]  left_x;
    logic [7:0]  right_y;
    logic [7:0]  right_x;
    logic [7:0]  controller_type;
    logic [7:0]  mode;
    logic [15:0] falling;
    logic [15:0] rising;
    logic [15:0] held;
    logic [3:0]  entry;
  } out_beat_t;

endpackage

>>> design/gprd_frame_buf.sv
// Frame byte buffer: one write port, one registered read port, per-entry valid bits.
// Depends on gprd_pkg (byte width).
`timescale 1ns / 1ps

module gprd_frame_buf
  import gprd_pkg::*;
#(
  parameter int DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [BYTE_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [BYTE_W-1:0]        rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [BYTE_W-1:0] rd_mem;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem <= mem[rd_addr];
    end
  end

  // An entry never written reads as zero, which matches the cleared buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_mem : '0;

endmodule

>>> design/gamepad_response_decoder_unit.sv
// Gamepad poll response decoder: a final byte is accepted, then the buffer is swept
// (positions 2..21 read through the one read port) and then 1 or 13 result beats go
// out, one per cycle when the sink is ready. Input is refused during the sweep and
// while results go out.
// Reset (rst, synchronous, active high) clears all decoded state and the buffer valid bits.
// Depends on gprd_pkg and gprd_frame_buf.
`timescale 1ns / 1ps

module gamepad_response_decoder_unit
  import gprd_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input beat. tdata fields from bit 0: tx_byte[7:0], rx_byte[15:8], button_mask[31:16].
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,   // last_byte
  // Result beat. tdata fields from bit 0: entry[3:0], held[19:4], rising[35:20],
  // falling[51:36], mode[59:52], controller_type[67:60], right_x[75:68],
  // right_y[83:76], left_x[91:84], left_y[99:92], pressure[107:100], zero pad[111:108].
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast    // last
);

  localparam int AW = $clog2(FRAME_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  position;
  logic [5:0]  pos_inc;
  logic        status_req;
  logic        sweep_status;
  logic [15:0] mask_q;
  logic [15:0] buttons_now;
  logic [15:0] buttons_before;
  logic [7:0]  btn_lo;
  logic [7:0]  mode_held;
  logic [7:0]  type_held;
  logic [7:0]  sticks [4];
  logic [7:0]  pressures [12];

  // Sweep sequencer: issue side and response side of the buffer read port.
  logic [4:0]  iss_pos;
  logic        iss_on;
  logic [4:0]  resp_pos;
  logic        resp_on;
  logic [3:0]  emit_k;

  logic        in_fire;
  logic        out_free;
  logic        mode_valid;
  logic        wr_en;
  logic        rd_en;
  logic [7:0]  rd_data;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  logic [15:0] button_mask;
  out_beat_t   beat_q;
  out_beat_t   beat_next;
  logic        beat_last;

  assign tx_byte     = s_axis_tdata[7:0];
  assign rx_byte     = s_axis_tdata[15:8];
  assign button_mask = s_axis_tdata[31:16];

  // Input is taken only when no frame end is being decoded or reported.
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Position counts from 1 and saturates; bytes at or past the buffer depth are dropped.
  assign pos_inc = (position != 6'd63) ? position + 6'd1 : position;
  assign wr_en   = in_fire && ({1'b0, pos_inc} < 7'(FRAME_DEPTH));
  assign rd_en   = (state == ST_SWEEP) && iss_on;

  assign mode_valid = (mode_held == MODE_DIGITAL) || (mode_held == MODE_ANALOG) ||
                      (mode_held == MODE_PRESSURE);

  gprd_frame_buf #(
    .DEPTH(FRAME_DEPTH)
  ) u_frame_buf (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(pos_inc[AW-1:0]),
    .wr_data(rx_byte),
    .rd_en  (rd_en),
    .rd_addr(AW'(iss_pos)),
    .rd_data(rd_data)
  );

  // Beat zero is the summary; beats one to twelve carry one pressure each with the
  // other fields zero. Only pressure mode produces the pressure beats.
  always_comb begin
    beat_next       = '0;
    beat_next.entry = emit_k;
    if (emit_k == 4'd0) begin
      beat_next.held            = buttons_now & mask_q;
      beat_next.rising          = buttons_now & ~buttons_before & mask_q;
      beat_next.falling         = ~buttons_now & buttons_before & mask_q;
      beat_next.mode            = mode_held;
      beat_next.controller_type = type_held;
      beat_next.right_x         = sticks[0];
      beat_next.right_y         = sticks[1];
      beat_next.left_x          = sticks[2];
      beat_next.left_y          = sticks[3];
      beat_last                 = (mode_held != MODE_PRESSURE);
    end else begin
      beat_next.pressure = pressures[emit_k - 4'd1];
      beat_last          = (emit_k == NUM_PRESS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      position       <= '0;
      status_req     <= 1'b0;
      sweep_status   <= 1'b0;
      mask_q         <= '0;
      buttons_now    <= '0;
      buttons_before <= '0;
      btn_lo         <= '0;
      mode_held      <= '0;
      type_held      <= '0;
      for (int i = 0; i < 4; i++) begin
        sticks[i] <= '0;
      end
      for (int i = 0; i < 12; i++) begin
        pressures[i] <= '0;
      end
      iss_pos        <= '0;
      iss_on         <= 1'b0;
      resp_pos       <= '0;
      resp_on        <= 1'b0;
      emit_k         <= '0;
      m_axis_tvalid  <= 1'b0;
      m_axis_tlast   <= 1'b0;
      beat_q         <= '0;
    end else begin
      // While results go out, the emit state itself decides the next valid.
      if (m_axis_tvalid && m_axis_tready && (state != ST_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tlast) begin
              // The status request flag is consumed by this frame end and cleared.
              position     <= '0;
              status_req   <= 1'b0;
              sweep_status <= (pos_inc == 6'd2) ? (tx_byte == CMD_STATUS) : status_req;
              mask_q       <= button_mask;
              iss_pos      <= POS_MODE;
              iss_on       <= 1'b1;
              resp_on      <= 1'b0;
              state        <= ST_SWEEP;
            end else begin
              position <= pos_inc;
              if (pos_inc == 6'd2) begin
                status_req <= (tx_byte == CMD_STATUS);
              end
            end
          end
        end
        ST_SWEEP: begin
          if (iss_on) begin
            iss_pos <= iss_pos + 5'd1;
            if (iss_pos == POS_SWEEP_END) begin
              iss_on <= 1'b0;
            end
          end
          resp_on  <= iss_on;
          resp_pos <= iss_pos;
          if (resp_on) begin
            // The mode byte returns first, so later positions see this frame's mode.
            priority if (resp_pos == POS_MODE) begin
              mode_held <= rd_data;
            end else if (resp_pos == POS_BTN_LO) begin
              btn_lo <= rd_data;
              if (sweep_status) begin
                type_held <= rd_data;
              end
            end else if (resp_pos == POS_BTN_HI) begin
              if (mode_valid) begin
                buttons_before <= buttons_now;
                buttons_now    <= ~{rd_data, btn_lo};
              end
            end else if (resp_pos >= POS_STICK0 && resp_pos <= POS_STICK3) begin
              if (mode_held == MODE_ANALOG || mode_held == MODE_PRESSURE) begin
                sticks[2'(resp_pos - POS_STICK0)] <= rd_data;
              end
            end else if (resp_pos >= POS_PRESS0) begin
              if (mode_held == MODE_PRESSURE) begin
                pressures[4'(resp_pos - POS_PRESS0)] <= rd_data;
              end
            end else begin
              // Position 3 carries nothing the decoder keeps.
            end
            if (resp_pos == POS_SWEEP_END) begin
              emit_k <= '0;
              state  <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            beat_q        <= beat_next;
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= beat_last;
            emit_k        <= emit_k + 4'd1;
            if (beat_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = beat_q;

`ifndef ASSERT_OFF
  a_out_held_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

  a_press_last_is_twelve: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && beat_q.entry != 4'd0) |-> (beat_q.entry == NUM_PRESS))
    else $error("pressure run ended early");

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tlast) |=> (position == 6'd0 && state == ST_SWEEP))
    else $error("frame end did not restart position");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("buffer read during byte write");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for gamepad_response_decoder_unit: directed poll frames, then random ones.
// Each beat is predicted with an in-bench decoder model and checked field by field.
// Depends on gprd_pkg and the design sources under design/.
`timescale 1ns / 1ps

module testbench;
  import gprd_pkg::*;

  localparam int DEPTH     = FRAME_DEPTH_DEF;
  localparam int N_BYTES   = 460;
  localparam int SETTLE    = 60;
  localparam int LIMIT_NS  = 12_000_000;

  typedef struct {
    logic [7:0]  tx;
    logic [7:0]  rx;
    logic        eof;
    logic [15:0] mask;
    bit          fixed;
    out_beat_t   fixed_beat;
    logic        fixed_last;
  } poll_byte_t;

  typedef struct {
    out_beat_t beat;
    logic      lst;
  } result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  poll_byte_t stim[$];
  poll_byte_t in_flight[$];
  result_t    expected_beats[$];
  int         errors = 0;
  int         stall_pct = 0;

  // Decoder state mirrored by the bench.
  int          frame_pos;
  logic [7:0]  frame_buf[DEPTH];
  logic        status_pending;
  logic [15:0] btn_now;
  logic [15:0] btn_prev;
  logic [7:0]  mode_q;
  logic [7:0]  ctype_q;
  logic [7:0]  stick[4];
  logic [7:0]  press[12];

  gamepad_response_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic out_beat_t summary_beat(logic [15:0] held, logic [15:0] rising,
                                             logic [15:0] falling, logic [7:0] mode,
                                             logic [7:0] ctype, logic [7:0] rx_,
                                             logic [7:0] ry, logic [7:0] lx, logic [7:0] ly);
    out_beat_t b;
    b = '0;
    b.held = held;
    b.rising = rising;
    b.falling = falling;
    b.mode = mode;
    b.controller_type = ctype;
    b.right_x = rx_;
    b.right_y = ry;
    b.left_x = lx;
    b.left_y = ly;
    return b;
  endfunction

  function automatic void reset_decoder_state();
    frame_pos = 0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    status_pending = 1'b0;
    btn_now = '0;
    btn_prev = '0;
    mode_q = '0;
    ctype_q = '0;
    foreach (stick[i]) stick[i] = '0;
    foreach (press[i]) press[i] = '0;
  endfunction

  // Takes one accepted byte and appends the beats it causes to expected_beats.
  function automatic void decode_poll_byte(logic [7:0] tx, logic [7:0] rx, logic eof,
                                           logic [15:0] mask);
    result_t r;
    logic    pressure_mode;
    if (frame_pos < 63) frame_pos++;
    if (frame_pos < DEPTH) frame_buf[frame_pos] = rx;
    if (frame_pos == 2) status_pending = (tx == CMD_STATUS);
    if (!eof) return;

    mode_q = frame_buf[2];
    if (mode_q == MODE_DIGITAL || mode_q == MODE_ANALOG || mode_q == MODE_PRESSURE) begin
      btn_prev = btn_now;
      btn_now = ~{frame_buf[5], frame_buf[4]};
      if (mode_q != MODE_DIGITAL)
        for (int i = 0; i < 4; i++) stick[i] = frame_buf[6 + i];
      if (mode_q == MODE_PRESSURE)
        for (int i = 0; i < 12; i++) press[i] = frame_buf[10 + i];
    end
    if (status_pending) ctype_q = frame_buf[4];
    status_pending = 1'b0;
    frame_pos = 0;

    pressure_mode = (mode_q == MODE_PRESSURE);
    r.beat = summary_beat(btn_now & mask, btn_now & ~btn_prev & mask,
                          ~btn_now & btn_prev & mask, mode_q, ctype_q,
                          stick[0], stick[1], stick[2], stick[3]);
    r.lst = !pressure_mode;
    expected_beats.push_back(r);
    if (pressure_mode)
      for (int k = 1; k <= 12; k++) begin
        r.beat = '0;
        r.beat.entry = k[3:0];
        r.beat.pressure = press[k - 1];
        r.lst = (k == 12);
        expected_beats.push_back(r);
      end
  endfunction

  task automatic add_byte(logic [7:0] tx, logic [7:0] rx, logic eof, logic [15:0] mask);
    poll_byte_t p;
    p.tx = tx;
    p.rx = rx;
    p.eof = eof;
    p.mask = mask;
    p.fixed = 1'b0;
    p.fixed_beat = '0;
    p.fixed_last = 1'b0;
    stim.push_back(p);
  endtask

  task automatic add_checked(logic [7:0] tx, logic [7:0] rx, logic [15:0] mask,
                             out_beat_t beat, logic lst);
    add_byte(tx, rx, 1'b1, mask);
    stim[$].fixed = 1'b1;
    stim[$].fixed_beat = beat;
    stim[$].fixed_last = lst;
  endtask

  task automatic build_directed();
    // One-byte frame straight after reset: mode reads as zero, nothing decoded.
    add_checked(8'hFF, 8'hFF, 16'hFFFF, summary_beat('0, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b1);
    // Pressure frame that is also a status request.
    add_byte(8'h01, 8'hFF, 1'b0, 16'h0000);
    add_byte(CMD_STATUS, MODE_PRESSURE, 1'b0, 16'h0000);
    add_byte(8'hFF, 8'h5A, 1'b0, 16'h0000);
    add_byte(8'h00, 8'h3C, 1'b0, 16'h0000);
    add_byte(8'h00, 8'hC3, 1'b0, 16'h0000);
    add_byte(8'h00, 8'h00, 1'b0, 16'h0000);
    add_byte(8'h00, 8'hFF, 1'b0, 16'h0000);
    add_byte(8'h00, 8'h01, 1'b0, 16'h0000);
    add_byte(8'h00, 8'h80, 1'b0, 16'h0000);
    for (int i = 10; i <= 21; i++)
      add_byte(8'h00, (i == 10) ? 8'h00 : (i == 11) ? 8'hFF : 8'(i * 11), 1'b0, 16'h0000);
    add_checked(8'h00, 8'hAA, 16'hFFFF,
                summary_beat(16'h3CC3, 16'h3CC3, 16'h0000, MODE_PRESSURE, 8'h3C,
                             8'h00, 8'hFF, 8'h01, 8'h80), 1'b0);
    // Two-byte status request with an unknown mode: buttons, sticks and type are held.
    add_byte(8'h00, 8'h00, 1'b0, 16'h0000);
    add_checked(CMD_STATUS, 8'h13, 16'h5555,
                summary_beat(16'h1441, 16'h1441, 16'h0000, 8'h13, 8'h3C,
                             8'h00, 8'hFF, 8'h01, 8'h80), 1'b1);
  endtask

  // Mostly well-formed frames with random content; some short, some past the buffer.
  task automatic build_random();
    int          r, len, need;
    logic [7:0]  mode, tx, rx;
    logic [15:0] mask;
    bit          status;
    while (stim.size() < N_BYTES) begin
      r = $urandom_range(99);
      mode = (r < 25) ? MODE_DIGITAL : (r < 50) ? MODE_ANALOG :
             (r < 75) ? MODE_PRESSURE : 8'($urandom_range(255));
      need = (mode == MODE_DIGITAL) ? 5 : (mode == MODE_ANALOG) ? 9 :
             (mode == MODE_PRESSURE) ? 21 : 5;
      r = $urandom_range(99);
      if (r < 72) len = need + $urandom_range(3);
      else if (r < 93) len = $urandom_range(need, 1);
      else len = $urandom_range(70, 22);
      status = ($urandom_range(2) == 0);
      for (int pos = 1; pos <= len; pos++) begin
        tx = 8'($urandom_range(255));
        rx = 8'($urandom_range(255));
        if (pos == 2) begin
          rx = mode;
          if (status) tx = CMD_STATUS;
        end
        r = $urandom_range(99);
        mask = (r < 20) ? 16'hFFFF : (r < 25) ? 16'h0000 : 16'($urandom_range(65535));
        add_byte(tx, rx, pos == len, mask);
      end
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Output stall generator; the driver sets the stall rate per phase.
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : monitor
    poll_byte_t p;
    result_t    want;
    out_beat_t  got;
    int         base;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      if (in_flight.size() == 0) begin
        $error("input beat accepted with nothing driven");
        errors++;
      end else begin
        p = in_flight.pop_front();
        base = expected_beats.size();
        decode_poll_byte(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast,
                         s_axis_tdata[31:16]);
        if (p.fixed) begin
          expected_beats[base].beat = p.fixed_beat;
          expected_beats[base].lst = p.fixed_last;
        end
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: entry %0d", got.entry);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("entry", want.beat.entry, got.entry);
        check_field("held", want.beat.held, got.held);
        check_field("rising", want.beat.rising, got.rising);
        check_field("falling", want.beat.falling, got.falling);
        check_field("mode", want.beat.mode, got.mode);
        check_field("controller_type", want.beat.controller_type, got.controller_type);
        check_field("right_x", want.beat.right_x, got.right_x);
        check_field("right_y", want.beat.right_y, got.right_y);
        check_field("left_x", want.beat.left_x, got.left_x);
        check_field("left_y", want.beat.left_y, got.left_y);
        check_field("pressure", want.beat.pressure, got.pressure);
        check_field("last", want.lst, m_axis_tlast);
      end
    end
  end

  initial begin : driver
    int         n_directed, phase, send_idle, guard;
    poll_byte_t p;
    reset_decoder_state();
    build_directed();
    n_directed = stim.size();
    build_random();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phases over the random part: free running, sender gaps, sink stalls, both.
    foreach (stim[idx]) begin
      phase = (idx < n_directed) ? 0 : ((idx - n_directed) * 4) / (stim.size() - n_directed);
      send_idle = (phase == 1) ? 88 : (phase == 3) ? 19 : 0;
      stall_pct = (phase == 2) ? 88 : (phase == 3) ? 19 : 0;
      while ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      p = stim[idx];
      in_flight.push_back(p);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {p.mask, p.rx, p.tx};
      s_axis_tlast <= p.eof;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    @(posedge clk);

    guard = 0;
    while (expected_beats.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);

    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
